// File: src/elmi_pkg.sv
// Shared types and codes for the E-LMI UNI-C polling step.
// No dependencies; used by elmi_step and elmi_uni_c_polling_step.
package elmi_pkg;

  localparam int LIMIT_W  = 4;
  localparam int PERIOD_W = 16;
  localparam int TMO_W    = 32;
  localparam int CFG_W    = 16;

  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 4'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd360;
  localparam logic [LIMIT_W-1:0]  MISS_MAX   = 4'd15;
  localparam logic [TMO_W-1:0]    TMO_MAX    = 32'hFFFF_FFFF;

  localparam logic       CFG_STATUS_LIMIT     = 1'b0;
  localparam logic       CFG_FULL_POLL_PERIOD = 1'b1;

  localparam logic [1:0] REQ_ECHECK      = 2'd0;
  localparam logic [1:0] REQ_FULL        = 2'd1;
  localparam logic [1:0] REQ_FULL_CONT   = 2'd2;

  localparam logic       REPORT_ECHECK   = 1'b0;
  localparam logic       REPORT_FULL     = 1'b1;

  typedef struct packed {
    logic       response_received;
    logic [1:0] last_request;
  } in_t;

  typedef struct packed {
    logic             poll_kind;
    logic             down_notice;
    logic             clear_success;
    logic             link_down;
    logic [TMO_W-1:0] timeout_count;
  } out_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] poll_countdown;
    logic [LIMIT_W-1:0]  miss_count;
    logic                down_flag;
    logic [TMO_W-1:0]    timeouts;
  } state_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  status_limit;
    logic [PERIOD_W-1:0] full_poll_period;
  } cfg_t;

endpackage

// File: src/elmi_step.sv
// Next-state and result logic for one polling timer expiry.
// Depends on elmi_pkg.
module elmi_step import elmi_pkg::*; (
  input  in_t    req,
  input  state_t cur,
  input  cfg_t   cfg,
  output state_t nxt,
  output out_t   res
);

  logic [PERIOD_W-1:0] pc_dec;
  logic [LIMIT_W-1:0]  miss_inc;
  logic                missed;
  logic                last_full;
  logic                pc_zero;
  logic                trip;

  always_comb begin
    missed    = ~req.response_received;
    last_full = (req.last_request == REQ_FULL) || (req.last_request == REQ_FULL_CONT);
    pc_dec    = (cur.poll_countdown != '0) ? cur.poll_countdown - 1'b1 : '0;
    pc_zero   = (pc_dec == '0);
    miss_inc  = (cur.miss_count < MISS_MAX) ? cur.miss_count + 1'b1 : cur.miss_count;
    trip      = missed && (miss_inc >= cfg.status_limit);

    nxt.poll_countdown = pc_zero ? cfg.full_poll_period : pc_dec;
    nxt.timeouts       = (missed && cur.timeouts != TMO_MAX) ? cur.timeouts + 1'b1
                                                              : cur.timeouts;
    nxt.down_flag      = cur.down_flag | trip;
    if (trip) begin
      nxt.miss_count = '0;
    end else if (missed) begin
      nxt.miss_count = miss_inc;
    end else begin
      nxt.miss_count = cur.miss_count;
    end

    res.poll_kind     = (pc_zero || (missed && last_full)) ? REPORT_FULL : REPORT_ECHECK;
    res.down_notice   = trip & ~cur.down_flag;
    res.clear_success = missed;
    res.link_down     = nxt.down_flag;
    res.timeout_count = nxt.timeouts;
  end

endmodule

// File: src/elmi_uni_c_polling_step.sv
// Top level of the E-LMI UNI-C polling step: request and result registers,
// configuration registers and polling state. Depends on elmi_pkg, elmi_step.
//
// Usage: each request on the in_ channel is one polling timer expiry carrying
// response_received and last_request. A request is taken at a clock edge with
// in_valid high and in_stall low; results leave on the out_ channel under the
// same rule with out_valid and out_stall.
// Path: a taken request passes through the request register, then the result
// register. Throughput: one request per cycle while out_stall is low; the
// request register and the result register are the only stages, and the
// polling state updates as a request moves into the result register.
// Stall: while out_stall holds a result, the next request waits in the
// request register and in_stall rises only once that register is full.
// Configuration: cfg_we writes status_limit (index 0) or full_poll_period
// (index 1) from cfg_wdata; write only while the block is idle.
// Reset (rst_n low, synchronous): both channels empty, status_limit 4,
// full_poll_period 360, countdown, miss and timeout counts zero, link up.
module elmi_uni_c_polling_step import elmi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic   req_vld_r;
  in_t    req_r;
  logic   res_vld_r;
  out_t   res_r;
  state_t st_r;
  cfg_t   cfg_r;
  state_t st_nxt;
  out_t   res_nxt;
  logic   adv;
  logic   take;

  elmi_step u_step (
    .req (req_r),
    .cur (st_r),
    .cfg (cfg_r),
    .nxt (st_nxt),
    .res (res_nxt)
  );

  assign adv       = req_vld_r && (!res_vld_r || !out_stall);
  assign in_stall  = req_vld_r && !adv;
  assign take      = in_valid && !in_stall;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      st_r      <= '0;
      cfg_r.status_limit     <= LIMIT_RST;
      cfg_r.full_poll_period <= PERIOD_RST;
    end else begin
      req_vld_r <= take || (req_vld_r && !adv);
      if (adv) begin
        res_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STATUS_LIMIT:     cfg_r.status_limit     <= cfg_wdata[LIMIT_W-1:0];
          CFG_FULL_POLL_PERIOD: cfg_r.full_poll_period <= cfg_wdata[PERIOD_W-1:0];
          default:              cfg_r.status_limit     <= cfg_r.status_limit;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_data;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

endmodule
